/* design/hmr_pkg.sv */
// ----------------------------------------------------------------------------
// hmr_pkg
// Shared widths, register indexes, command/status types and state encodings
// for the midpoint hyperbola rasterizer.
// ----------------------------------------------------------------------------
package hmr_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int AXIS_BITS_DEF  = 9;

    localparam int OFS_W     = 12;          // x / y offset registers
    localparam int CNT_W     = 10;          // step counter and config registers
    localparam int DEC_W     = 48;          // decision value, kept as 4F
    localparam int OUT_W     = 13;          // signed output coordinates
    localparam int MUL_B_W   = OFS_W + 1;   // narrow multiplier operand
    localparam int SUM_W     = OFS_W + 2;   // centre +/- offset before clamp
    localparam int CFG_IDX_W = 1;

    localparam int OUT_MIN = -2048;
    localparam int OUT_MAX = 4095;

    localparam logic [CNT_W-1:0] TAIL_STEPS_RST = CNT_W'(100);
    localparam logic [CNT_W-1:0] HEAD_LIMIT_RST = CNT_W'(1023);

    localparam logic [CFG_IDX_W-1:0] REG_TAIL_STEPS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_LIMIT = CFG_IDX_W'(1);

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef enum logic [1:0] {
        PH_DONE,
        PH_HEAD,
        PH_TAIL
    } phase_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_HEAD,
        EMIT_TAIL
    } emit_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_MUL_AA,
        DP_MUL_BB,
        DP_MUL_A2B,
        DP_MUL_PB,
        DP_MUL_B2T,
        DP_MUL_PT,
        DP_MUL_B2A,
        DP_HEAD_INIT,
        DP_CHECK,
        DP_HEAD_STEP,
        DP_TAIL_ENTER,
        DP_MUL_B2X,
        DP_MUL_PX,
        DP_MUL_A2Y,
        DP_MUL_PY,
        DP_TAIL_DEC,
        DP_TAIL_STEP,
        DP_END
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
        emit_t  emit;
    } dp_cmd_t;

    typedef struct packed {
        phase_t phase;
        logic   head_go;    // another head step is due
        logic   tail_zero;  // tail count configured as zero
        logic   tail_done;  // tail count reached
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_AA,
        ST_MUL_BB,
        ST_MUL_A2B,
        ST_MUL_PB,
        ST_MUL_B2T,
        ST_MUL_PT,
        ST_MUL_B2A,
        ST_HEAD_INIT,
        ST_CHECK,
        ST_MUL_B2X,
        ST_MUL_PX,
        ST_MUL_A2Y,
        ST_MUL_PY,
        ST_TAIL_DEC,
        ST_TAIL,
        ST_OUT
    } ctl_state_t;

endpackage

/* design/hmr_ctrl.sv */
// ----------------------------------------------------------------------------
// hmr_ctrl
// Sequencer: walks the start and region-change multiply chains, dispatches
// pixel steps and owns the result word valid flag.
// ----------------------------------------------------------------------------
module hmr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_op,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  hmr_pkg::dp_status_t status,
    output hmr_pkg::dp_cmd_t    cmd
);

    hmr_pkg::ctl_state_t state_reg, state_next;
    hmr_pkg::emit_t      emit_reg, emit_next;
    logic                m_valid_reg, m_valid_next;
    logic                step_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hmr_pkg::ST_IDLE;
            emit_reg    <= hmr_pkg::EMIT_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            emit_reg    <= emit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        emit_next    = emit_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.op       = hmr_pkg::DP_NOP;
        cmd.out_load = 1'b0;
        cmd.emit     = emit_reg;
        step_go      = 1'b0;

        unique case (state_reg)
            hmr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_op == hmr_pkg::OP_START) begin
                        cmd.op     = hmr_pkg::DP_LOAD;
                        emit_next  = hmr_pkg::EMIT_HEAD;
                        state_next = hmr_pkg::ST_MUL_AA;
                    end else begin
                        step_go = 1'b1;
                    end
                end
            end
            hmr_pkg::ST_MUL_AA: begin
                cmd.op     = hmr_pkg::DP_MUL_AA;
                state_next = hmr_pkg::ST_MUL_BB;
            end
            hmr_pkg::ST_MUL_BB: begin
                cmd.op     = hmr_pkg::DP_MUL_BB;
                state_next = hmr_pkg::ST_MUL_A2B;
            end
            hmr_pkg::ST_MUL_A2B: begin
                cmd.op     = hmr_pkg::DP_MUL_A2B;
                state_next = hmr_pkg::ST_MUL_PB;
            end
            hmr_pkg::ST_MUL_PB: begin
                cmd.op     = hmr_pkg::DP_MUL_PB;
                state_next = hmr_pkg::ST_MUL_B2T;
            end
            hmr_pkg::ST_MUL_B2T: begin
                cmd.op     = hmr_pkg::DP_MUL_B2T;
                state_next = hmr_pkg::ST_MUL_PT;
            end
            hmr_pkg::ST_MUL_PT: begin
                cmd.op     = hmr_pkg::DP_MUL_PT;
                state_next = hmr_pkg::ST_MUL_B2A;
            end
            hmr_pkg::ST_MUL_B2A: begin
                cmd.op     = hmr_pkg::DP_MUL_B2A;
                state_next = hmr_pkg::ST_HEAD_INIT;
            end
            hmr_pkg::ST_HEAD_INIT: begin
                cmd.op     = hmr_pkg::DP_HEAD_INIT;
                state_next = hmr_pkg::ST_CHECK;
            end
            hmr_pkg::ST_CHECK: begin
                cmd.op     = hmr_pkg::DP_CHECK;
                state_next = hmr_pkg::ST_OUT;
            end
            hmr_pkg::ST_MUL_B2X: begin
                cmd.op     = hmr_pkg::DP_MUL_B2X;
                state_next = hmr_pkg::ST_MUL_PX;
            end
            hmr_pkg::ST_MUL_PX: begin
                cmd.op     = hmr_pkg::DP_MUL_PX;
                state_next = hmr_pkg::ST_MUL_A2Y;
            end
            hmr_pkg::ST_MUL_A2Y: begin
                cmd.op     = hmr_pkg::DP_MUL_A2Y;
                state_next = hmr_pkg::ST_MUL_PY;
            end
            hmr_pkg::ST_MUL_PY: begin
                cmd.op     = hmr_pkg::DP_MUL_PY;
                state_next = hmr_pkg::ST_TAIL_DEC;
            end
            hmr_pkg::ST_TAIL_DEC: begin
                cmd.op     = hmr_pkg::DP_TAIL_DEC;
                state_next = hmr_pkg::ST_TAIL;
            end
            hmr_pkg::ST_TAIL: begin
                step_go = 1'b1;
            end
            hmr_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = hmr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hmr_pkg::ST_IDLE;
            end
        endcase

        // pixel step dispatch, shared by a fresh step word and the first
        // tail pixel after the region change
        if (step_go) begin
            case (status.phase)
                hmr_pkg::PH_HEAD: begin
                    if (status.head_go) begin
                        cmd.op     = hmr_pkg::DP_HEAD_STEP;
                        emit_next  = hmr_pkg::EMIT_HEAD;
                        state_next = hmr_pkg::ST_CHECK;
                    end else if (status.tail_zero) begin
                        cmd.op     = hmr_pkg::DP_END;
                        emit_next  = hmr_pkg::EMIT_NONE;
                        state_next = hmr_pkg::ST_OUT;
                    end else begin
                        cmd.op     = hmr_pkg::DP_TAIL_ENTER;
                        state_next = hmr_pkg::ST_MUL_B2X;
                    end
                end
                hmr_pkg::PH_TAIL: begin
                    if (status.tail_done) begin
                        cmd.op     = hmr_pkg::DP_END;
                        emit_next  = hmr_pkg::EMIT_NONE;
                    end else begin
                        cmd.op     = hmr_pkg::DP_TAIL_STEP;
                        emit_next  = hmr_pkg::EMIT_TAIL;
                    end
                    state_next = hmr_pkg::ST_OUT;
                end
                default: begin
                    emit_next  = hmr_pkg::EMIT_NONE;
                    state_next = hmr_pkg::ST_OUT;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == hmr_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

/* design/hmr_dp.sv */
// ----------------------------------------------------------------------------
// hmr_dp
// Datapath: centre/axis registers, offsets, incremental difference terms,
// 4F decision register, one shared 48x13 multiplier, config registers and
// the output word register.
// ----------------------------------------------------------------------------
module hmr_dp #(
    parameter int COORD_BITS = hmr_pkg::COORD_BITS_DEF,
    parameter int AXIS_BITS  = hmr_pkg::AXIS_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [hmr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [hmr_pkg::CNT_W-1:0]            cfg_wr_data,
    input  logic [COORD_BITS-1:0]                s_center_x,
    input  logic [COORD_BITS-1:0]                s_center_y,
    input  logic [AXIS_BITS-1:0]                 s_semi_major,
    input  logic [AXIS_BITS-1:0]                 s_semi_minor,
    input  hmr_pkg::dp_cmd_t                     cmd,
    output hmr_pkg::dp_status_t                  status,
    output logic                                 m_point_valid,
    output logic                                 m_last_point,
    output logic signed [hmr_pkg::OUT_W-1:0]     m_right_x,
    output logic signed [hmr_pkg::OUT_W-1:0]     m_left_x,
    output logic signed [hmr_pkg::OUT_W-1:0]     m_lower_y,
    output logic signed [hmr_pkg::OUT_W-1:0]     m_upper_y,
    output logic                                 m_in_tail
);

    localparam int OFS_W   = hmr_pkg::OFS_W;
    localparam int CNT_W   = hmr_pkg::CNT_W;
    localparam int DEC_W   = hmr_pkg::DEC_W;
    localparam int OUT_W   = hmr_pkg::OUT_W;
    localparam int MUL_B_W = hmr_pkg::MUL_B_W;
    localparam int SUM_W   = hmr_pkg::SUM_W;
    localparam int A2_W    = 2 * AXIS_BITS;
    localparam int CMP_W   = A2_W + OFS_W + 1;

    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(hmr_pkg::OUT_MIN);
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(hmr_pkg::OUT_MAX);

    function automatic logic signed [OUT_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        c = v;
        if (v < SAT_LO) c = SAT_LO;
        if (v > SAT_HI) c = SAT_HI;
        return c[OUT_W-1:0];
    endfunction

    // curve registers
    logic [COORD_BITS-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [AXIS_BITS-1:0]  a_reg, a_next, b_reg, b_next;
    logic [OFS_W-1:0]      x_reg, x_next, y_reg, y_next;
    logic [A2_W-1:0]       a2_reg, a2_next, b2_reg, b2_next;
    logic [CMP_W-1:0]      ay_reg, ay_next, bx_reg, bx_next;
    logic [DEC_W-1:0]      ab_reg, ab_next, dx_reg, dx_next, dy_reg, dy_next;
    logic [DEC_W-1:0]      dec_reg, dec_next, tmp_reg, tmp_next, mul_reg;
    logic                  geo_reg, geo_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    hmr_pkg::phase_t       phase_reg, phase_next;
    logic [CNT_W-1:0]      tail_steps_reg, head_limit_reg;

    // output word
    logic                    out_valid_reg, out_last_reg, out_tail_reg;
    logic signed [OUT_W-1:0] out_rx_reg, out_lx_reg, out_ly_reg, out_uy_reg;

    // multiplier
    logic [DEC_W-1:0]   mul_a, mul_prod;
    logic [MUL_B_W-1:0] mul_b, t_val, xp1_val, y2p1_val;
    logic               mul_en;

    logic               dec_pos, dec_neg, head_go, tail_zero, tail_done;
    logic [CMP_W-1:0]   bx_plus;
    logic [DEC_W-1:0]   a2_x4, a2_x8, b2_x4, b2_x8;
    logic signed [SUM_W-1:0] cx_s, cy_s, x_s, y_s;

    assign dec_neg = dec_reg[DEC_W-1];
    assign dec_pos = !dec_neg && (dec_reg != '0);

    assign a2_x4   = DEC_W'(a2_reg) << 2;
    assign a2_x8   = DEC_W'(a2_reg) << 3;
    assign b2_x4   = DEC_W'(b2_reg) << 2;
    assign b2_x8   = DEC_W'(b2_reg) << 3;
    assign bx_plus = bx_reg + CMP_W'(b2_reg);

    assign t_val    = MUL_B_W'({a_reg, 1'b1});
    assign xp1_val  = MUL_B_W'(x_reg) + MUL_B_W'(1);
    assign y2p1_val = MUL_B_W'({y_reg, 1'b1});

    assign head_go   = (cnt_reg < head_limit_reg) && geo_reg;
    assign tail_zero = (tail_steps_reg == '0);
    assign tail_done = (cnt_reg >= tail_steps_reg);

    assign status.phase     = phase_reg;
    assign status.head_go   = head_go;
    assign status.tail_zero = tail_zero;
    assign status.tail_done = tail_done;

    // operand selection for the shared multiplier
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (cmd.op)
            hmr_pkg::DP_MUL_AA: begin
                mul_a = DEC_W'(a_reg);
                mul_b = MUL_B_W'(a_reg);
            end
            hmr_pkg::DP_MUL_BB: begin
                mul_a = DEC_W'(b_reg);
                mul_b = MUL_B_W'(b_reg);
            end
            hmr_pkg::DP_MUL_A2B: begin
                mul_a = DEC_W'(a2_reg);
                mul_b = MUL_B_W'(b_reg);
            end
            hmr_pkg::DP_MUL_PB: begin
                mul_a = mul_reg;
                mul_b = MUL_B_W'(b_reg);
            end
            hmr_pkg::DP_MUL_B2T: begin
                mul_a = DEC_W'(b2_reg);
                mul_b = t_val;
            end
            hmr_pkg::DP_MUL_PT: begin
                mul_a = mul_reg;
                mul_b = t_val;
            end
            hmr_pkg::DP_MUL_B2A: begin
                mul_a = DEC_W'(b2_reg);
                mul_b = MUL_B_W'(a_reg);
            end
            hmr_pkg::DP_MUL_B2X: begin
                mul_a = DEC_W'(b2_reg);
                mul_b = xp1_val;
            end
            hmr_pkg::DP_MUL_PX: begin
                mul_a = mul_reg;
                mul_b = xp1_val;
            end
            hmr_pkg::DP_MUL_A2Y: begin
                mul_a = DEC_W'(a2_reg);
                mul_b = y2p1_val;
            end
            hmr_pkg::DP_MUL_PY: begin
                mul_a = mul_reg;
                mul_b = y2p1_val;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // low DEC_W bits only; the decision wraps at that width anyway
    assign mul_prod = mul_a * mul_b;

    always_comb begin
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        a2_next    = a2_reg;
        b2_next    = b2_reg;
        ab_next    = ab_reg;
        ay_next    = ay_reg;
        bx_next    = bx_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        dec_next   = dec_reg;
        tmp_next   = tmp_reg;
        geo_next   = geo_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;

        unique case (cmd.op)
            hmr_pkg::DP_LOAD: begin
                cx_next    = s_center_x;
                cy_next    = s_center_y;
                a_next     = s_semi_major;
                b_next     = s_semi_minor;
                x_next     = OFS_W'(s_semi_major);
                y_next     = '0;
                cnt_next   = '0;
                phase_next = hmr_pkg::PH_HEAD;
            end
            hmr_pkg::DP_MUL_BB: begin
                a2_next = A2_W'(mul_reg);
            end
            hmr_pkg::DP_MUL_A2B: begin
                b2_next = A2_W'(mul_reg);
            end
            hmr_pkg::DP_MUL_B2T: begin
                ab_next = mul_reg;
            end
            hmr_pkg::DP_MUL_B2A: begin
                // 4F at (a+1/2, 1): b2(2a+1)^2 - 4a2 - 4a2b2
                dec_next = mul_reg - a2_x4 - (ab_reg << 2);
            end
            hmr_pkg::DP_HEAD_INIT: begin
                bx_next = CMP_W'(mul_reg);
                ay_next = CMP_W'(a2_reg);
                dx_next = (mul_reg + DEC_W'(b2_reg)) << 3;
                dy_next = a2_x8 + a2_x4;
            end
            hmr_pkg::DP_CHECK: begin
                // a2*(y+1) <= b2*(x + next x step)
                geo_next = dec_pos ? (ay_reg <= bx_reg) : (ay_reg <= bx_plus);
            end
            hmr_pkg::DP_HEAD_STEP: begin
                if (dec_pos) begin
                    dec_next = dec_reg - dy_reg;
                end else begin
                    dec_next = dec_reg + dx_reg - dy_reg;
                    x_next   = x_reg + OFS_W'(1);
                    bx_next  = bx_plus;
                    dx_next  = dx_reg + b2_x8;
                end
                y_next   = y_reg + OFS_W'(1);
                ay_next  = ay_reg + CMP_W'(a2_reg);
                dy_next  = dy_reg + a2_x8;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            hmr_pkg::DP_TAIL_ENTER: begin
                // head terms 4b2(2x+2), 4a2(2y+3) -> tail 4b2(2x+3), 4a2(2y+2)
                cnt_next   = '0;
                phase_next = hmr_pkg::PH_TAIL;
                dx_next    = dx_reg + b2_x4;
                dy_next    = dy_reg - a2_x4;
            end
            hmr_pkg::DP_MUL_A2Y: begin
                tmp_next = mul_reg;
            end
            hmr_pkg::DP_TAIL_DEC: begin
                dec_next = (tmp_reg << 2) - mul_reg - (ab_reg << 2);
            end
            hmr_pkg::DP_TAIL_STEP: begin
                if (!dec_neg) begin
                    dec_next = dec_reg + dx_reg - dy_reg;
                    y_next   = y_reg + OFS_W'(1);
                    dy_next  = dy_reg + a2_x8;
                end else begin
                    dec_next = dec_reg + dx_reg;
                end
                x_next   = x_reg + OFS_W'(1);
                dx_next  = dx_reg + b2_x8;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            hmr_pkg::DP_END: begin
                cnt_next   = '0;
                phase_next = hmr_pkg::PH_DONE;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= hmr_pkg::PH_DONE;
            cnt_reg        <= '0;
            tail_steps_reg <= hmr_pkg::TAIL_STEPS_RST;
            head_limit_reg <= hmr_pkg::HEAD_LIMIT_RST;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    hmr_pkg::REG_TAIL_STEPS: tail_steps_reg <= cfg_wr_data;
                    hmr_pkg::REG_HEAD_LIMIT: head_limit_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        cx_reg  <= cx_next;
        cy_reg  <= cy_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        a2_reg  <= a2_next;
        b2_reg  <= b2_next;
        ab_reg  <= ab_next;
        ay_reg  <= ay_next;
        bx_reg  <= bx_next;
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        dec_reg <= dec_next;
        tmp_reg <= tmp_next;
        geo_reg <= geo_next;
        if (mul_en) begin
            mul_reg <= mul_prod;
        end
    end

    // output word
    assign cx_s = SUM_W'(cx_reg);
    assign cy_s = SUM_W'(cy_reg);
    assign x_s  = SUM_W'(x_reg);
    assign y_s  = SUM_W'(y_reg);

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            case (cmd.emit) inside
                hmr_pkg::EMIT_HEAD, hmr_pkg::EMIT_TAIL: begin
                    out_valid_reg <= 1'b1;
                    out_last_reg  <= (cmd.emit == hmr_pkg::EMIT_TAIL) ? tail_done
                                                                      : (tail_zero && !head_go);
                    out_tail_reg  <= (cmd.emit == hmr_pkg::EMIT_TAIL);
                    out_rx_reg    <= sat_coord(cx_s + x_s);
                    out_lx_reg    <= sat_coord(cx_s - x_s);
                    out_ly_reg    <= sat_coord(cy_s + y_s);
                    out_uy_reg    <= sat_coord(cy_s - y_s);
                end
                default: begin
                    out_valid_reg <= 1'b0;
                    out_last_reg  <= 1'b0;
                    out_tail_reg  <= 1'b0;
                    out_rx_reg    <= '0;
                    out_lx_reg    <= '0;
                    out_ly_reg    <= '0;
                    out_uy_reg    <= '0;
                end
            endcase
        end
    end

    assign m_point_valid = out_valid_reg;
    assign m_last_point  = out_last_reg;
    assign m_in_tail     = out_tail_reg;
    assign m_right_x     = out_rx_reg;
    assign m_left_x      = out_lx_reg;
    assign m_lower_y     = out_ly_reg;
    assign m_upper_y     = out_uy_reg;

endmodule

/* design/hyperbola_midpoint_raster.sv */
// ----------------------------------------------------------------------------
// hyperbola_midpoint_raster
// Midpoint rasterizer for a centred hyperbola x^2/a^2 - y^2/b^2 = 1.
// ----------------------------------------------------------------------------
// Usage:
//   s_* is the input word channel (valid/ready). op = start loads the centre
//   and semi-axes and returns the vertex; op = step advances one pixel and
//   returns the four mirrored coordinates, or an invalid word once the curve
//   is finished. m_* returns exactly one result word per input word.
//   cfg_wr_en/cfg_index/cfg_wr_data write tail_steps (index 0) and
//   head_limit (index 1); write them only while no word is in flight.
// Per input word, from accept through ST_OUT (which loads the result word)
// back to idle: start: load, MUL_AA/BB/A2B/PB/B2T/PT/B2A, head init, check;
//   head pixel: step, check; tail pixel or invalid: step dispatch only;
//   region change pixel: tail enter, MUL_B2X/PX/A2Y/PY, tail dec, tail step.
//   The multiply chains share one 48x13 multiplier; pixel steps use adders.
// Reset (aresetn, synchronous, active low) leaves the block idle with no
// curve active and the registers at tail_steps 100, head_limit 1023.
// A stalled receiver holds the result in the output register; the next input
// word is taken and computed meanwhile, then waits for that register.
// ----------------------------------------------------------------------------
module hyperbola_midpoint_raster #(
    parameter int COORD_BITS = hmr_pkg::COORD_BITS_DEF,
    parameter int AXIS_BITS  = hmr_pkg::AXIS_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [hmr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [hmr_pkg::CNT_W-1:0]            cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_op,
    input  logic [COORD_BITS-1:0]                s_center_x,
    input  logic [COORD_BITS-1:0]                s_center_y,
    input  logic [AXIS_BITS-1:0]                 s_semi_major,
    input  logic [AXIS_BITS-1:0]                 s_semi_minor,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_point_valid,
    output logic                                 m_last_point,
    output logic signed [hmr_pkg::OUT_W-1:0]     m_right_x,
    output logic signed [hmr_pkg::OUT_W-1:0]     m_left_x,
    output logic signed [hmr_pkg::OUT_W-1:0]     m_lower_y,
    output logic signed [hmr_pkg::OUT_W-1:0]     m_upper_y,
    output logic                                 m_in_tail
);

    hmr_pkg::dp_cmd_t    cmd;
    hmr_pkg::dp_status_t status;

    hmr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    hmr_dp #(
        .COORD_BITS (COORD_BITS),
        .AXIS_BITS  (AXIS_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_center_x    (s_center_x),
        .s_center_y    (s_center_y),
        .s_semi_major  (s_semi_major),
        .s_semi_minor  (s_semi_minor),
        .cmd           (cmd),
        .status        (status),
        .m_point_valid (m_point_valid),
        .m_last_point  (m_last_point),
        .m_right_x     (m_right_x),
        .m_left_x      (m_left_x),
        .m_lower_y     (m_lower_y),
        .m_upper_y     (m_upper_y),
        .m_in_tail     (m_in_tail)
    );

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hyperbola_midpoint_raster. Start and step words go
// in with random gaps while the result side stalls at random; each result
// word is checked against a midpoint predictor kept inside the bench, over
// several register settings including zero and full-scale counts.
// ----------------------------------------------------------------------------
module tb;

    localparam int CB        = hmr_pkg::COORD_BITS_DEF;
    localparam int AB        = hmr_pkg::AXIS_BITS_DEF;
    localparam int OUT_W     = hmr_pkg::OUT_W;
    localparam int CFG_IDX_W = hmr_pkg::CFG_IDX_W;
    localparam int CNT_W     = hmr_pkg::CNT_W;
    localparam int OFS_W     = hmr_pkg::OFS_W;
    localparam int DEC_W     = hmr_pkg::DEC_W;

    typedef struct packed {
        logic          op;
        logic [CB-1:0] cx;
        logic [CB-1:0] cy;
        logic [AB-1:0] semi_a;
        logic [AB-1:0] semi_b;
    } cmd_word_t;

    typedef struct packed {
        logic                    point_valid;
        logic                    last_point;
        logic signed [OUT_W-1:0] right_x;
        logic signed [OUT_W-1:0] left_x;
        logic signed [OUT_W-1:0] lower_y;
        logic signed [OUT_W-1:0] upper_y;
        logic                    in_tail;
    } pixel_word_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = hmr_pkg::REG_TAIL_STEPS;
    logic [CNT_W-1:0]        cfg_wr_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_op = hmr_pkg::OP_START;
    logic [CB-1:0]           s_center_x = '0;
    logic [CB-1:0]           s_center_y = '0;
    logic [AB-1:0]           s_semi_major = '0;
    logic [AB-1:0]           s_semi_minor = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_point_valid;
    logic                    m_last_point;
    logic signed [OUT_W-1:0] m_right_x;
    logic signed [OUT_W-1:0] m_left_x;
    logic signed [OUT_W-1:0] m_lower_y;
    logic signed [OUT_W-1:0] m_upper_y;
    logic                    m_in_tail;

    hyperbola_midpoint_raster dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_center_x    (s_center_x),
        .s_center_y    (s_center_y),
        .s_semi_major  (s_semi_major),
        .s_semi_minor  (s_semi_minor),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_valid (m_point_valid),
        .m_last_point  (m_last_point),
        .m_right_x     (m_right_x),
        .m_left_x      (m_left_x),
        .m_lower_y     (m_lower_y),
        .m_upper_y     (m_upper_y),
        .m_in_tail     (m_in_tail)
    );

    always #1 aclk = ~aclk;

    cmd_word_t   pending_words[$];
    pixel_word_t raster_q[$];
    cmd_word_t   next_cmd;
    pixel_word_t got_word;
    pixel_word_t want_word;
    int          mismatches = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    bit          quiet = 1'b0;

    // predictor state, starts at the reset values
    logic [CNT_W-1:0] tail_cfg = hmr_pkg::TAIL_STEPS_RST;
    logic [CNT_W-1:0] head_cfg = hmr_pkg::HEAD_LIMIT_RST;
    logic [CB-1:0]    cen_col = '0;
    logic [CB-1:0]    cen_row = '0;
    logic [AB-1:0]    ax_a = AB'(1);
    logic [AB-1:0]    ax_b = AB'(1);
    logic [OFS_W-1:0] ofs_x = '0;
    logic [OFS_W-1:0] ofs_y = '0;
    logic [DEC_W-1:0] dec_val = '0;
    logic [CNT_W-1:0] step_cnt = '0;
    hmr_pkg::phase_t  draw_phase = hmr_pkg::PH_DONE;

    function automatic bit dec_pos();
        return !dec_val[DEC_W-1] && dec_val != '0;
    endfunction

    // next head step exists and stays above the slope-one point
    function automatic bit head_more();
        bit [63:0] a2, b2, nx, ny;
        a2 = 64'(ax_a) * 64'(ax_a);
        b2 = 64'(ax_b) * 64'(ax_b);
        nx = 64'(ofs_x) + (dec_pos() ? 64'd0 : 64'd1);
        ny = 64'(ofs_y) + 64'd1;
        if (step_cnt >= head_cfg)
            return 1'b0;
        return a2 * ny <= b2 * nx;
    endfunction

    function automatic logic signed [OUT_W-1:0] place(logic [CB-1:0] c,
                                                      logic [OFS_W-1:0] o, bit minus);
        int v;
        v = minus ? int'(c) - int'(o) : int'(c) + int'(o);
        if (v < hmr_pkg::OUT_MIN)
            v = hmr_pkg::OUT_MIN;
        if (v > hmr_pkg::OUT_MAX)
            v = hmr_pkg::OUT_MAX;
        return OUT_W'(v);
    endfunction

    function automatic pixel_word_t pixel(bit valid, bit last, bit tail);
        pixel_word_t w;
        w = '0;
        if (valid) begin
            w.point_valid = 1'b1;
            w.last_point  = last;
            w.right_x     = place(cen_col, ofs_x, 1'b0);
            w.left_x      = place(cen_col, ofs_x, 1'b1);
            w.lower_y     = place(cen_row, ofs_y, 1'b0);
            w.upper_y     = place(cen_row, ofs_y, 1'b1);
            w.in_tail     = tail;
        end
        return w;
    endfunction

    // Decision is 4F at the midpoint, modulo 2^48.
    function automatic pixel_word_t advance_raster(cmd_word_t cmd);
        bit [63:0] a2, b2, x, y, t;
        if (cmd.op == hmr_pkg::OP_START) begin
            cen_col  = cmd.cx;
            cen_row  = cmd.cy;
            ax_a     = cmd.semi_a;
            ax_b     = cmd.semi_b;
            a2       = 64'(ax_a) * 64'(ax_a);
            b2       = 64'(ax_b) * 64'(ax_b);
            t        = 2 * 64'(ax_a) + 1;
            ofs_x    = OFS_W'(ax_a);
            ofs_y    = '0;
            step_cnt = '0;
            dec_val  = DEC_W'(b2 * t * t - 4 * a2 - 4 * a2 * b2);
            draw_phase = hmr_pkg::PH_HEAD;
            return pixel(1'b1, tail_cfg == 0 && !head_more(), 1'b0);
        end
        a2 = 64'(ax_a) * 64'(ax_a);
        b2 = 64'(ax_b) * 64'(ax_b);
        x  = 64'(ofs_x);
        y  = 64'(ofs_y);
        if (draw_phase == hmr_pkg::PH_HEAD) begin
            if (head_more()) begin
                if (dec_pos()) begin
                    dec_val = DEC_W'(64'(dec_val) - 4 * a2 * (2 * y + 3));
                end else begin
                    dec_val = DEC_W'(64'(dec_val) + 4 * b2 * (2 * x + 2)
                                     - 4 * a2 * (2 * y + 3));
                    ofs_x = ofs_x + OFS_W'(1);
                end
                ofs_y    = ofs_y + OFS_W'(1);
                step_cnt = step_cnt + CNT_W'(1);
                return pixel(1'b1, tail_cfg == 0 && !head_more(), 1'b0);
            end
            step_cnt = '0;
            if (tail_cfg == 0) begin
                draw_phase = hmr_pkg::PH_DONE;
                return pixel(1'b0, 1'b0, 1'b0);
            end
            // region change: restart the decision at (x+1, y+1/2)
            t = 2 * y + 1;
            dec_val = DEC_W'(4 * b2 * (x + 1) * (x + 1) - a2 * t * t - 4 * a2 * b2);
            draw_phase = hmr_pkg::PH_TAIL;
        end
        if (draw_phase == hmr_pkg::PH_TAIL) begin
            if (step_cnt >= tail_cfg) begin
                draw_phase = hmr_pkg::PH_DONE;
                return pixel(1'b0, 1'b0, 1'b0);
            end
            if (!dec_val[DEC_W-1]) begin
                dec_val = DEC_W'(64'(dec_val) + 4 * b2 * (2 * x + 3)
                                 - 4 * a2 * (2 * y + 2));
                ofs_y = ofs_y + OFS_W'(1);
            end else begin
                dec_val = DEC_W'(64'(dec_val) + 4 * b2 * (2 * x + 3));
            end
            ofs_x    = ofs_x + OFS_W'(1);
            step_cnt = step_cnt + CNT_W'(1);
            return pixel(1'b1, step_cnt >= tail_cfg, 1'b1);
        end
        return pixel(1'b0, 1'b0, 1'b0);
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return CNT_W'(1023);
        if (r < 5)
            return CNT_W'($urandom_range(1, 8));
        return CNT_W'($urandom_range(1, 40));
    endfunction

    task automatic push_start(logic [CB-1:0] cx, logic [CB-1:0] cy,
                              logic [AB-1:0] sa, logic [AB-1:0] sb);
        pending_words.push_back(cmd_word_t'{hmr_pkg::OP_START, cx, cy, sa, sb});
    endtask

    // unused fields of a step word carry random junk
    task automatic push_step(int n);
        for (int i = 0; i < n; i++)
            pending_words.push_back(cmd_word_t'{hmr_pkg::OP_STEP, CB'($urandom),
                                                CB'($urandom), AB'($urandom),
                                                AB'($urandom)});
    endtask

    task automatic push_random_curve(int n);
        push_start(CB'($urandom), CB'($urandom),
                   $urandom_range(0, 1) ? AB'($urandom_range(0, 24)) : AB'($urandom),
                   $urandom_range(0, 1) ? AB'($urandom_range(0, 24)) : AB'($urandom));
        push_step(n);
    endtask

    task automatic wait_idle();
        do
            @(negedge aclk);
        while (pending_words.size() != 0 || s_valid || raster_q.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        if (idx == hmr_pkg::REG_TAIL_STEPS)
            tail_cfg = val;
        else
            head_cfg = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic flag_word(string why, pixel_word_t want, pixel_word_t got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t %s: expected v%0b l%0b x %0d/%0d y %0d/%0d t%0b,",
                      " got v%0b l%0b x %0d/%0d y %0d/%0d t%0b"},
                     $realtime, why,
                     want.point_valid, want.last_point, want.right_x, want.left_x,
                     want.lower_y, want.upper_y, want.in_tail,
                     got.point_valid, got.last_point, got.right_x, got.left_x,
                     got.lower_y, got.upper_y, got.in_tail);
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready)
                raster_q.push_back(advance_raster(cmd_word_t'{s_op, s_center_x,
                                   s_center_y, s_semi_major, s_semi_minor}));
            if (s_valid && !s_ready) begin
                // hold the word until taken
            end else if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (pending_words.size() != 0) begin
                next_cmd = pending_words.pop_front();
                s_valid      <= 1'b1;
                s_op         <= next_cmd.op;
                s_center_x   <= next_cmd.cx;
                s_center_y   <= next_cmd.cy;
                s_semi_major <= next_cmd.semi_a;
                s_semi_minor <= next_cmd.semi_b;
                gap_left     <= quiet ? 0 : pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got_word = pixel_word_t'{m_point_valid, m_last_point, m_right_x, m_left_x,
                                         m_lower_y, m_upper_y, m_in_tail};
                if (raster_q.size() == 0) begin
                    flag_word("unexpected word", '0, got_word);
                end else begin
                    want_word = raster_q.pop_front();
                    if (got_word.point_valid !== want_word.point_valid
                        || got_word.last_point !== want_word.last_point
                        || got_word.right_x !== want_word.right_x
                        || got_word.left_x !== want_word.left_x
                        || got_word.lower_y !== want_word.lower_y
                        || got_word.upper_y !== want_word.upper_y
                        || got_word.in_tail !== want_word.in_tail)
                        flag_word("mismatch", want_word, got_word);
                end
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < 15) begin
                stall_left <= pick_gap();
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int               budget;
        int               lim;
        int               n;
        logic [CNT_W-1:0] tail_set;
        logic [CNT_W-1:0] head_set;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: step with no curve, axis extremes, zero axes
        push_step(1);
        push_start(0, 0, 1, 1);
        push_step(2);
        push_start(1023, 1023, 511, 511);
        push_step(2);
        push_start(512, 300, 0, 7);
        push_step(1);
        push_start(5, 1000, 9, 0);
        push_step(1);
        wait_idle();

        // no tail and no head: the vertex is the last point
        write_reg(hmr_pkg::REG_TAIL_STEPS, 0);
        write_reg(hmr_pkg::REG_HEAD_LIMIT, 0);
        @(negedge aclk);
        push_start(0, 1023, 40, 3);
        push_step(2);
        wait_idle();

        // tail starts right at the vertex
        write_reg(hmr_pkg::REG_TAIL_STEPS, 3);
        @(negedge aclk);
        push_start(1023, 0, 300, 200);
        push_step(5);
        wait_idle();

        // full-scale counts on a long curve
        write_reg(hmr_pkg::REG_TAIL_STEPS, 1023);
        write_reg(hmr_pkg::REG_HEAD_LIMIT, 1023);
        @(negedge aclk);
        push_start(0, 0, 511, 511);
        push_step(300);
        wait_idle();

        for (int ph = 0; ph < 10; ph++) begin
            tail_set = pick_count();
            head_set = pick_count();
            if (ph != 3 || $urandom_range(0, 1))
                write_reg(hmr_pkg::REG_TAIL_STEPS, tail_set);
            else
                tail_set = tail_cfg;
            write_reg(hmr_pkg::REG_HEAD_LIMIT, head_set);
            @(negedge aclk);
            quiet = (ph % 4 == 2);
            // a few steps first so an unfinished curve meets the new counts
            push_step($urandom_range(0, 4));
            budget = 110;
            while (budget > 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    pending_words.push_back(cmd_word_t'($urandom));
                    budget--;
                end else begin
                    lim = int'(head_set) + int'(tail_set) + 3;
                    if (lim > 60)
                        lim = 60;
                    n = $urandom_range(0, lim);
                    push_random_curve(n);
                    budget -= n + 1;
                end
            end
            wait_idle();
        end

        repeat (30) @(posedge aclk);
        if (raster_q.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
